// ===== sv/dwecs_pkg.sv =====
// Shared types, constants and command/status structs for the depth-weighted EMA crossover block.
`default_nettype none
package dwecs_pkg;
  localparam int unsigned BOOK_DEPTH = 3;
  localparam int unsigned LVL_W = 5;
  localparam int unsigned PRICE_W = 24;
  localparam int unsigned PSUM_W = 52;
  localparam int unsigned QSUM_W = 28;
  localparam int unsigned AVG_W = 40;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned WARM_W = 16;
  localparam int unsigned DIV_STEPS = 69;
  localparam int unsigned DCNT_W = 7;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd21627;
  localparam logic [WARM_W-1:0] WARM_RST = 16'd120;

  localparam logic CFG_EMA_WEIGHT = 1'b0;
  localparam logic CFG_WARMUP = 1'b1;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_BUY = 2'd1;
  localparam logic [1:0] SIG_SELL = 2'd2;

  localparam logic [1:0] DIR_NEUTRAL = 2'd0;
  localparam logic [1:0] DIR_SELLING = 2'd1;
  localparam logic [1:0] DIR_BUYING = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_EMA, ST_DIR, ST_OUT
  } state_t;

  typedef struct packed {
    logic accum;
    logic clear_model;
    logic div_start;
    logic div_step;
    logic mul_load;
    logic ema_load;
    logic dir_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== sv/depth_weighted_ema_crossover_signal.sv =====
// Top level of the depth-weighted EMA crossover signal block.
//
//  channel | ports                      | direction
//  in      | in_tvalid/tready/tdata/tlast/tuser | book levels, reset action
//  out     | out_tvalid/tready/tdata/tuser      | one result per final level
//  cfg     | cfg_valid/ready/index/data         | register writes
//
// A level request or reset action is taken while idle. A final level holds the input
// through the serial restoring dividers (load, 68 quotient bits, done), then
// multiply, EMA, direction and output steps; its result appears as in_tready returns.
// rst_n is synchronous; registers return to 21627 / 120.
// The output register holds a result while out_tready is low; input stalls
// only while a snapshot is being worked on or its result cannot be stored.
`default_nettype none
module depth_weighted_ema_crossover_signal (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: bid price, bid qty, ask price, ask qty (lowest first)
  input  wire logic [95:0]  in_tdata,
  input  wire logic         in_tlast,
  // tuser: action
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: bid average, ask average (lowest first)
  output logic [79:0]       out_tdata,
  // tuser: signal, direction, snapshot_valid, averages_ready (lowest first)
  output logic [5:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [16:0]  cfg_data
);
  import dwecs_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic [WEIGHT_W-1:0] weight_r;
  logic [WARM_W-1:0] warm_cfg_r;
  logic out_valid_r;
  logic [79:0] out_data_r;
  logic [5:0] out_user_r;
  logic [1:0] r_sig, r_dir;
  logic r_valid, r_ready;
  logic [AVG_W-1:0] r_bid, r_ask;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RST;
      warm_cfg_r <= WARM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EMA_WEIGHT: weight_r <= cfg_data;
        CFG_WARMUP:     warm_cfg_r <= cfg_data[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  dwecs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_action(in_tuser), .in_last(in_tlast),
    .out_busy(out_valid_r && !out_tready), .sts(sts), .cmd(cmd)
  );

  dwecs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .bid_px(in_tdata[23:0]), .bid_qty(in_tdata[47:24]),
    .ask_px(in_tdata[71:48]), .ask_qty(in_tdata[95:72]),
    .ema_weight(weight_r), .warmup_samples(warm_cfg_r),
    .res_signal(r_sig), .res_direction(r_dir), .res_valid(r_valid),
    .res_ready(r_ready), .res_bid(r_bid), .res_ask(r_ask)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {r_ask, r_bid};
      out_user_r <= {r_ready, r_valid, r_dir, r_sig};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
endmodule
`default_nettype wire

// ===== sv/dwecs_ctrl.sv =====
// Controller state machine sequencing accumulate, divide, multiply, EMA, direction and output steps.
`default_nettype none
module dwecs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic           in_action,
  input  wire logic           in_last,
  input  wire logic           out_busy,
  input  wire dwecs_pkg::sts_t sts,
  output dwecs_pkg::cmd_t     cmd
);
  import dwecs_pkg::*;
  state_t state_r, state_nxt;
  logic take;

  assign in_tready = (state_r == ST_IDLE);
  assign take = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (take && !in_action && in_last) state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_EMA;
      ST_EMA:  state_nxt = ST_DIR;
      ST_DIR:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accum = take && !in_action;
        cmd.clear_model = take && in_action;
        cmd.div_start = take && !in_action && in_last;
      end
      ST_DIV: cmd.div_step = !sts.div_done;
      ST_MUL: cmd.mul_load = 1'b1;
      ST_EMA: cmd.ema_load = 1'b1;
      ST_DIR: cmd.dir_load = 1'b1;
      ST_OUT: cmd.out_load = !out_busy;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/dwecs_dp.sv =====
// Datapath: level accumulators, serial dividers, EMA multipliers and direction logic.
`default_nettype none
module dwecs_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dwecs_pkg::cmd_t               cmd,
  output dwecs_pkg::sts_t                    sts,
  input  wire logic [dwecs_pkg::PRICE_W-1:0] bid_px,
  input  wire logic [dwecs_pkg::PRICE_W-1:0] bid_qty,
  input  wire logic [dwecs_pkg::PRICE_W-1:0] ask_px,
  input  wire logic [dwecs_pkg::PRICE_W-1:0] ask_qty,
  input  wire logic [dwecs_pkg::WEIGHT_W-1:0] ema_weight,
  input  wire logic [dwecs_pkg::WARM_W-1:0]   warmup_samples,
  output logic [1:0]                         res_signal,
  output logic [1:0]                         res_direction,
  output logic                               res_valid,
  output logic                               res_ready,
  output logic [dwecs_pkg::AVG_W-1:0]        res_bid,
  output logic [dwecs_pkg::AVG_W-1:0]        res_ask
);
  import dwecs_pkg::*;
  logic [PSUM_W-1:0] bps_r, aps_r;
  logic [QSUM_W-1:0] bqs_r, aqs_r;
  logic [LVL_W-1:0] lvl_r;
  logic nz_r;
  logic [AVG_W-1:0] bavg_r, aavg_r;
  logic seeded_r;
  logic [WARM_W-1:0] warm_r;
  logic sell_r, buy_r;
  logic valid_r;
  logic [1:0] sig_r;

  // Restoring dividers: numerator is p<<16 (68 bits), one quotient bit a cycle.
  logic [PSUM_W+15:0] bnum_r, anum_r;
  logic [QSUM_W:0] brem_r, arem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [AVG_W-1:0] bfast_r, afast_r;
  logic [QSUM_W:0] btry, atry;

  // EMA products, registered
  logic [AVG_W+WEIGHT_W-1:0] bm1_r, bm2_r, am1_r, am2_r;
  logic [WEIGHT_W-1:0] w_sat;
  logic [AVG_W+WEIGHT_W:0] bsum, asum;
  logic warm_dec_zero;

  assign w_sat = (ema_weight > WEIGHT_ONE) ? WEIGHT_ONE : ema_weight;
  assign sts.div_done = (dcnt_r == DCNT_W'(DIV_STEPS));
  assign btry = {brem_r[QSUM_W-1:0], bnum_r[PSUM_W+15]};
  assign atry = {arem_r[QSUM_W-1:0], anum_r[PSUM_W+15]};

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_model || cmd.out_load) begin
      bps_r <= '0; aps_r <= '0; bqs_r <= '0; aqs_r <= '0;
      lvl_r <= '0; nz_r <= 1'b1;
    end else if (cmd.accum) begin
      if (lvl_r < LVL_W'(BOOK_DEPTH)) begin
        bps_r <= bps_r + PSUM_W'(bid_px * bid_qty);
        aps_r <= aps_r + PSUM_W'(ask_px * ask_qty);
        bqs_r <= bqs_r + QSUM_W'(bid_qty);
        aqs_r <= aqs_r + QSUM_W'(ask_qty);
        if (bid_qty == '0 || ask_qty == '0) nz_r <= 1'b0;
      end
      if (lvl_r < LVL_W'(BOOK_DEPTH + 1)) lvl_r <= lvl_r + 1'b1;
    end
  end

  // level count already includes the last level once div starts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      bnum_r <= '0; anum_r <= '0; brem_r <= '0; arem_r <= '0;
    end else if (cmd.div_step) begin
      if (dcnt_r == '0) begin
        // load numerators; sums are final now
        bnum_r <= {bps_r, 16'h0};
        anum_r <= {aps_r, 16'h0};
      end else begin
        if (btry >= {1'b0, bqs_r}) begin
          brem_r <= btry - {1'b0, bqs_r};
          bnum_r <= {bnum_r[PSUM_W+14:0], 1'b1};
        end else begin
          brem_r <= btry;
          bnum_r <= {bnum_r[PSUM_W+14:0], 1'b0};
        end
        if (atry >= {1'b0, aqs_r}) begin
          arem_r <= atry - {1'b0, aqs_r};
          anum_r <= {anum_r[PSUM_W+14:0], 1'b1};
        end else begin
          arem_r <= atry;
          anum_r <= {anum_r[PSUM_W+14:0], 1'b0};
        end
      end
    end
  end
  // dcnt 0 loads, steps 1..68 consume all 68 numerator bits;
  // the numerator register then holds the full quotient.

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      bfast_r <= (bqs_r == '0) ? '0 : bnum_r[AVG_W-1:0];
      afast_r <= (aqs_r == '0) ? '0 : anum_r[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ema_load) begin
      bm1_r <= bfast_r * w_sat;
      am1_r <= afast_r * w_sat;
      bm2_r <= bavg_r * (WEIGHT_ONE - w_sat);
      am2_r <= aavg_r * (WEIGHT_ONE - w_sat);
    end
  end

  assign bsum = {1'b0, bm1_r} + {1'b0, bm2_r};
  assign asum = {1'b0, am1_r} + {1'b0, am2_r};
  assign warm_dec_zero = (warm_r <= WARM_W'(1));

  always_ff @(posedge clk) begin
    logic [AVG_W-1:0] nb, na;
    logic rdy, s, b;
    logic [1:0] sg;
    if (!rst_n || cmd.clear_model) begin
      bavg_r <= '0; aavg_r <= '0; seeded_r <= 1'b0;
      warm_r <= rst_n ? warmup_samples : WARM_RST;
      sell_r <= 1'b0; buy_r <= 1'b0; valid_r <= 1'b0; sig_r <= SIG_NONE;
    end else if (cmd.dir_load) begin
      valid_r <= (lvl_r == LVL_W'(BOOK_DEPTH)) && nz_r;
      sig_r <= SIG_NONE;
      if ((lvl_r == LVL_W'(BOOK_DEPTH)) && nz_r) begin
        nb = seeded_r ? bsum[AVG_W+15:16] : bfast_r;
        na = seeded_r ? asum[AVG_W+15:16] : afast_r;
        rdy = warm_dec_zero;
        s = sell_r; b = buy_r; sg = SIG_NONE;
        if (s) begin
          if (rdy && afast_r > na) begin sg = SIG_BUY; s = 1'b0; end
        end else if (afast_r < nb && afast_r < na) begin
          s = 1'b1; b = 1'b0;
        end
        if (b) begin
          if (rdy && bfast_r > nb) begin sg = SIG_SELL; b = 1'b0; end
        end else if (bfast_r > na && bfast_r > nb) begin
          b = 1'b1; s = 1'b0;
        end
        bavg_r <= nb; aavg_r <= na; seeded_r <= 1'b1;
        if (warm_r != '0) warm_r <= warm_r - 1'b1;
        sell_r <= s; buy_r <= b; sig_r <= sg;
      end
    end
  end

  assign res_signal = sig_r;
  assign res_direction = sell_r ? DIR_SELLING : (buy_r ? DIR_BUYING : DIR_NEUTRAL);
  assign res_valid = valid_r;
  assign res_ready = (warm_r == '0);
  assign res_bid = bavg_r;
  assign res_ask = aavg_r;
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the depth-weighted EMA crossover signal block.
`default_nettype none
module testbench;
  import dwecs_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;
  logic [5:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [16:0]  cfg_data = '0;

  localparam logic ACT_LEVEL = 1'b0;
  localparam logic ACT_RESET = 1'b1;
  localparam int   DRAIN_CYCLES = 200;

  // book request as seen on the input channel
  typedef struct {
    logic        act;
    logic [23:0] bp, bq, ap, aq;
    logic        last;
  } level_req_t;

  // one snapshot outcome
  typedef struct {
    logic [1:0]  sig;
    logic [1:0]  dir;
    logic        used;
    logic        ready;
    logic [39:0] bid_avg, ask_avg;
  } outcome_t;

  // directed row: request plus an optional typed-in expectation
  typedef struct {
    level_req_t req;
    bit         typed;
    outcome_t   want;
  } row_t;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  depth_weighted_ema_crossover_signal dut (.*);

  // predictor state
  logic [16:0]  weight_q;
  logic [15:0]  warmup_reg;
  logic [51:0]  bid_psum, ask_psum;
  logic [27:0]  bid_qsum, ask_qsum;
  logic [4:0]   levels_seen;
  logic         all_filled;
  logic [39:0]  bid_avg_q, ask_avg_q;
  logic         seeded;
  logic [15:0]  warm_left;
  logic         is_selling, is_buying;

  outcome_t outcome_q[$];
  int       errors = 0;
  bit       hold_off = 0;

  function automatic logic [39:0] weighted_price(logic [51:0] p, logic [27:0] q);
    logic [67:0] num;
    if (q == 0) return '0;
    num = {p, 16'h0};
    return 40'(num / q);
  endfunction

  function automatic logic [39:0] blend(logic [39:0] avg, logic [39:0] x, logic [16:0] w);
    logic [16:0] ws;
    logic [63:0] acc;
    ws  = (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
    acc = 64'(ws) * x + 64'(WEIGHT_ONE - ws) * avg;
    return 40'(acc >> 16);
  endfunction

  task automatic clear_book();
    bid_psum = '0; ask_psum = '0; bid_qsum = '0; ask_qsum = '0;
    levels_seen = '0; all_filled = 1'b1;
  endtask

  task automatic clear_averages();
    bid_avg_q = '0; ask_avg_q = '0; seeded = 1'b0;
    warm_left = warmup_reg; is_selling = 1'b0; is_buying = 1'b0;
  endtask

  // advance the predictor by one accepted request
  task automatic predict_level(level_req_t r);
    outcome_t o;
    logic [39:0] bf, af;
    logic ok;
    if (r.act == ACT_RESET) begin
      clear_book();
      clear_averages();
      return;
    end
    if (levels_seen < BOOK_DEPTH) begin
      bid_psum += 52'(r.bp) * r.bq;
      ask_psum += 52'(r.ap) * r.aq;
      bid_qsum += r.bq;
      ask_qsum += r.aq;
      if (r.bq == 0 || r.aq == 0) all_filled = 1'b0;
    end
    if (levels_seen < BOOK_DEPTH + 1) levels_seen++;
    if (!r.last) return;
    ok = (levels_seen == BOOK_DEPTH) && all_filled;
    o.sig = SIG_NONE;
    if (ok) begin
      bf = weighted_price(bid_psum, bid_qsum);
      af = weighted_price(ask_psum, ask_qsum);
      if (!seeded) begin
        bid_avg_q = bf; ask_avg_q = af; seeded = 1'b1;
      end else begin
        bid_avg_q = blend(bid_avg_q, bf, weight_q);
        ask_avg_q = blend(ask_avg_q, af, weight_q);
      end
      if (warm_left > 0) warm_left--;
      // selling branch first, then buying
      if (is_selling) begin
        if (warm_left == 0 && af > ask_avg_q) begin
          o.sig = SIG_BUY; is_selling = 1'b0;
        end
      end else if (af < bid_avg_q && af < ask_avg_q) begin
        is_selling = 1'b1; is_buying = 1'b0;
      end
      if (is_buying) begin
        if (warm_left == 0 && bf > bid_avg_q) begin
          o.sig = SIG_SELL; is_buying = 1'b0;
        end
      end else if (bf > ask_avg_q && bf > bid_avg_q) begin
        is_buying = 1'b1; is_selling = 1'b0;
      end
    end
    clear_book();
    o.dir     = is_selling ? DIR_SELLING : (is_buying ? DIR_BUYING : DIR_NEUTRAL);
    o.used    = ok;
    o.ready   = (warm_left == 0);
    o.bid_avg = bid_avg_q;
    o.ask_avg = ask_avg_q;
    outcome_q.push_back(o);
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;
  task automatic send_level(level_req_t r);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= r.act;
    in_tlast  <= r.last;
    in_tdata  <= {r.aq, r.ap, r.bq, r.bp};
    do @(posedge clk); while (!in_tready);
    predict_level(r);
  endtask

  task automatic write_reg(logic idx, logic [16:0] val);
    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_EMA_WEIGHT) weight_q = val;
    else warmup_reg = val[15:0];
  endtask

  function automatic level_req_t mk(logic act, logic [23:0] bp, bq, ap, aq, logic last);
    level_req_t r;
    r.act = act; r.bp = bp; r.bq = bq; r.ap = ap; r.aq = aq; r.last = last;
    return r;
  endfunction

  function automatic level_req_t rand_level(logic last, int mid);
    // prices near a wandering centre so crossings actually happen
    return mk(ACT_LEVEL, 24'(mid - 100 + $urandom_range(0, 200)), 24'($urandom_range(1, 5000)),
              24'(mid - 100 + $urandom_range(0, 200)), 24'($urandom_range(1, 5000)), last);
  endfunction

  // receiver: own stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk) begin
    outcome_t e, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.bid_avg = out_tdata[39:0];
      got.ask_avg = out_tdata[79:40];
      got.sig     = out_tuser[1:0];
      got.dir     = out_tuser[3:2];
      got.used    = out_tuser[4];
      got.ready   = out_tuser[5];
      if (outcome_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = outcome_q.pop_front();
        if (got.sig != e.sig) begin
          $error("signal exp %0d got %0d", e.sig, got.sig); errors++;
        end
        if (got.dir != e.dir) begin
          $error("direction exp %0d got %0d", e.dir, got.dir); errors++;
        end
        if (got.used != e.used) begin
          $error("snapshot_valid exp %0d got %0d", e.used, got.used); errors++;
        end
        if (got.ready != e.ready) begin
          $error("averages_ready exp %0d got %0d", e.ready, got.ready); errors++;
        end
        if (got.bid_avg != e.bid_avg) begin
          $error("bid_avg exp %h got %h", e.bid_avg, got.bid_avg); errors++;
        end
        if (got.ask_avg != e.ask_avg) begin
          $error("ask_avg exp %h got %h", e.ask_avg, got.ask_avg); errors++;
        end
      end
    end
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #4000000;
    $display("depth_weighted_ema_crossover_signal: mismatch");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    outcome_t z;
    int mid, n, k;
    bit pressed;
    logic [16:0] weights[4];
    logic [15:0] warms[4];

    pressed = 0;
    weight_q = WEIGHT_RST;
    warmup_reg = WARM_RST;
    clear_book();
    clear_averages();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    z = '{SIG_NONE, DIR_NEUTRAL, 1'b0, 1'b0, 40'd0, 40'd0};
    rw.typed = 0; rw.want = z;
    // lone final level straight after reset: too few levels
    rw.req = mk(ACT_LEVEL, 24'd5, 24'd5, 24'd5, 24'd5, 1'b1); rw.typed = 1; rows.push_back(rw);
    rw.typed = 0;
    // full snapshot at the extremes: seeds both averages
    rw.req = mk(ACT_LEVEL, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0); rows.push_back(rw);
    rw.req = mk(ACT_LEVEL, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0); rows.push_back(rw);
    rw.req = mk(ACT_LEVEL, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1); rows.push_back(rw);
    // empty quantities on two levels (bid on the first, ask on the last)
    rw.req = mk(ACT_LEVEL, 24'd10, 24'd0, 24'd11, 24'd3, 1'b0); rows.push_back(rw);
    rw.req = mk(ACT_LEVEL, 24'd10, 24'd3, 24'd11, 24'd3, 1'b0); rows.push_back(rw);
    rw.req = mk(ACT_LEVEL, 24'd10, 24'd3, 24'd11, 24'd0, 1'b1); rows.push_back(rw);
    // too many levels
    for (int i = 0; i < 5; i++) begin
      rw.req = mk(ACT_LEVEL, 24'd1, 24'd1, 24'd2, 24'd1, i == 4); rows.push_back(rw);
    end
    // reset action with junk fields discards a partial snapshot
    rw.req = mk(ACT_LEVEL, 24'd7, 24'd7, 24'd7, 24'd7, 1'b0); rows.push_back(rw);
    rw.req = mk(ACT_RESET, 24'hFFFFFF, 24'hABCDEF, 24'h123456, 24'hFFFFFF, 1'b1); rows.push_back(rw);
    // zero prices after the reset action: seeds at zero
    for (int i = 0; i < 3; i++) begin
      rw.req = mk(ACT_LEVEL, 24'd0, 24'd1, 24'd0, 24'hFFFFFF, i == 2); rows.push_back(rw);
    end
    // bid above ask: buying starts
    for (int i = 0; i < 3; i++) begin
      rw.req = mk(ACT_LEVEL, 24'd900, 24'd4, 24'd100, 24'd9, i == 2); rows.push_back(rw);
    end
    foreach (rows[i]) begin
      if (rows[i].typed) outcome_q.push_back(rows[i].want);
      send_level(rows[i].req);
      if (rows[i].typed) void'(outcome_q.pop_back());
    end

    // random phases over several register settings, extremes included
    weights = '{17'd1, 17'h10000, 17'h1FFFF, 17'd0};
    warms   = '{16'd0, 16'hFFFF, 16'd3, 16'd120};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_EMA_WEIGHT, ph == 4 ? 17'($urandom_range(1, 65536)) : weights[ph-1]);
        write_reg(CFG_WARMUP, warms[ph-1]);
        if (ph == 4) write_reg(CFG_EMA_WEIGHT, WEIGHT_RST);
        send_level(mk(ACT_RESET, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      1'($urandom)));
      end
      mid = $urandom_range(1000, 16000000);
      n = 0;
      while (n < 290) begin
        k = $urandom_range(0, 19);
        mid = mid + $urandom_range(0, 400) - 200;
        if (ph == 2 && n >= 100 && !pressed) begin
          pressed = 1;
          fork
            begin
              hold_off = 1;
              repeat (400) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        if (k == 0) begin
          // noise: random fields and last flag, with a one-in-sixteen chance of a reset action
          send_level(mk(1'($urandom_range(0, 15) == 0), 24'($urandom), 24'($urandom),
                        24'($urandom), 24'($urandom), 1'($urandom)));
          n++;
        end else if (k == 1) begin
          // short or long snapshot
          int len;
          len = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 2) : $urandom_range(4, 6);
          for (int i = 0; i < len; i++) send_level(rand_level(i == len - 1, mid));
          n += len;
        end else begin
          for (int i = 0; i < BOOK_DEPTH; i++) send_level(rand_level(i == BOOK_DEPTH - 1, mid));
          n += BOOK_DEPTH;
        end
      end
    end

    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("depth_weighted_ema_crossover_signal: match");
    else
      $display("depth_weighted_ema_crossover_signal: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/dwecs_pkg.sv
sv/dwecs_ctrl.sv
sv/dwecs_dp.sv
sv/depth_weighted_ema_crossover_signal.sv
sim/testbench.sv
